[hw/rtl/vom_pkg.sv]
// ----------------------------------------------------------------------------
// vom_pkg: shared definitions of the voxel occupancy marker
// Grid limits, datapath widths, register indexes, sequencer states and the
// configuration bundle that travels from the register bank to the core.
// ----------------------------------------------------------------------------
`default_nettype none

package vom_pkg;

    // Largest grid the bitmap can hold on each axis.
    localparam int MAX_GRID_X = 64;
    localparam int MAX_GRID_Y = 64;
    localparam int MAX_GRID_Z = 32;

    localparam int CELL_TOTAL = MAX_GRID_X * MAX_GRID_Y * MAX_GRID_Z;

    // Widths of clamped grid sizes and of per-axis indexes.
    localparam int SX_W = $clog2(MAX_GRID_X + 1);
    localparam int SY_W = $clog2(MAX_GRID_Y + 1);
    localparam int SZ_W = $clog2(MAX_GRID_Z + 1);
    localparam int IX_W = (MAX_GRID_X > 1) ? $clog2(MAX_GRID_X) : 1;
    localparam int IY_W = (MAX_GRID_Y > 1) ? $clog2(MAX_GRID_Y) : 1;
    localparam int IZ_W = (MAX_GRID_Z > 1) ? $clog2(MAX_GRID_Z) : 1;

    // Bitmap organization: one RAM row holds 64 voxel bits.
    localparam int BIT_W     = 6;
    localparam int ROW_W     = 1 << BIT_W;
    localparam int ROW_COUNT = (CELL_TOTAL + ROW_W - 1) / ROW_W;
    localparam int ROW_AW    = (ROW_COUNT > 1) ? $clog2(ROW_COUNT) : 1;
    localparam int KEY_W     = ($clog2(CELL_TOTAL) > BIT_W) ? $clog2(CELL_TOTAL) : BIT_W + 1;

    // Fixed-point datapath.
    localparam int COORD_W = 32;
    localparam int DIFF_W  = COORD_W + 1;
    localparam int INV_W   = 24;
    localparam int MUL_B_W = INV_W + 1;
    localparam int PROD_W  = DIFF_W + MUL_B_W;
    localparam int FRAC_W  = 32;
    localparam int IDXF_W  = PROD_W - 1 - FRAC_W;

    // Result fields.
    localparam int KEY_OUT_W = 17;
    localparam int COUNT_W   = 18;
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    // Configuration port.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ORIGIN_X   = 3'd0,
        REG_ORIGIN_Y   = 3'd1,
        REG_ORIGIN_Z   = 3'd2,
        REG_INV_WIDTH  = 3'd3,
        REG_GRID_X     = 3'd4,
        REG_GRID_Y     = 3'd5,
        REG_GRID_Z     = 3'd6,
        REG_ACCUMULATE = 3'd7
    } t_cfg_reg;

    typedef struct packed {
        logic signed [COORD_W-1:0] origin_x;
        logic signed [COORD_W-1:0] origin_y;
        logic signed [COORD_W-1:0] origin_z;
        logic [INV_W-1:0]          inverse_voxel_width;
        logic [6:0]                grid_size_x;
        logic [6:0]                grid_size_y;
        logic [5:0]                grid_size_z;
        logic                      accumulate;
    } t_cfg;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_MUL_X,
        S_MUL_Y,
        S_MUL_Z,
        S_KEY_Z,
        S_KEY_Y,
        S_READ,
        S_UPDATE
    } t_state;

endpackage

`default_nettype wire

[hw/rtl/vom_pt_if.sv]
// ----------------------------------------------------------------------------
// vom_pt_if: point channel
// Valid/ready channel that carries one 3-D point per word.
// ----------------------------------------------------------------------------
`default_nettype none

interface vom_pt_if;
    logic                                valid;
    logic                                ready;
    logic signed [vom_pkg::COORD_W-1:0]  point_x;
    logic signed [vom_pkg::COORD_W-1:0]  point_y;
    logic signed [vom_pkg::COORD_W-1:0]  point_z;
    logic                                point_valid;
    logic                                scan_start;

    modport source (
        output valid, point_x, point_y, point_z, point_valid, scan_start,
        input  ready
    );
    modport sink (
        input  valid, point_x, point_y, point_z, point_valid, scan_start,
        output ready
    );
endinterface

`default_nettype wire

[hw/rtl/vom_res_if.sv]
// ----------------------------------------------------------------------------
// vom_res_if: result channel
// Valid/ready channel that carries one marking result per word.
// ----------------------------------------------------------------------------
`default_nettype none

interface vom_res_if;
    logic                              valid;
    logic                              ready;
    logic                              in_map;
    logic [vom_pkg::KEY_OUT_W-1:0]     voxel_key;
    logic                              newly_marked;
    logic [vom_pkg::COUNT_W-1:0]       occupied_count;

    modport source (
        output valid, in_map, voxel_key, newly_marked, occupied_count,
        input  ready
    );
    modport sink (
        input  valid, in_map, voxel_key, newly_marked, occupied_count,
        output ready
    );
endinterface

`default_nettype wire

[hw/rtl/vom_ram.sv]
// ----------------------------------------------------------------------------
// vom_ram: generic simple dual-port RAM
// One write port and one read port with a registered read that holds its
// data while no read is issued.
// ----------------------------------------------------------------------------
`default_nettype none

module vom_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 2048,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

[hw/rtl/vom_mul.sv]
// ----------------------------------------------------------------------------
// vom_mul: shared signed multiplier
// A 33 x 25 bit signed multiply with a registered product, used in turn for
// the three axis scalings and the two steps of the voxel key.
// ----------------------------------------------------------------------------
`default_nettype none

module vom_mul (
    input  wire logic                               i_clk,
    input  wire logic signed [vom_pkg::DIFF_W-1:0]  i_a,
    input  wire logic signed [vom_pkg::MUL_B_W-1:0] i_b,
    output logic signed      [vom_pkg::PROD_W-1:0]  o_p
);

    logic signed [vom_pkg::PROD_W-1:0] n_p;

    // Full-precision product, extended before the multiply.
    assign n_p = vom_pkg::PROD_W'(i_a) * vom_pkg::PROD_W'(i_b);

    always_ff @(posedge i_clk) begin
        o_p <= n_p;
    end

endmodule

`default_nettype wire

[hw/rtl/vom_cfg.sv]
// ----------------------------------------------------------------------------
// vom_cfg: configuration register bank
// Holds the map origin, reciprocal voxel width, grid sizes and accumulate
// mode; written one register at a time through a plain write port.
// ----------------------------------------------------------------------------
`default_nettype none

module vom_cfg (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_we,
    input  wire logic [vom_pkg::CFG_IDX_W-1:0]     i_idx,
    input  wire logic [vom_pkg::CFG_DATA_W-1:0]    i_data,
    output vom_pkg::t_cfg                          o_cfg
);

    vom_pkg::t_cfg r_cfg;
    vom_pkg::t_cfg n_cfg;

    // Decode the register index.
    always_comb begin
        n_cfg = r_cfg;
        if (i_we) begin
            case (vom_pkg::t_cfg_reg'(i_idx))
                vom_pkg::REG_ORIGIN_X:   n_cfg.origin_x = signed'(i_data);
                vom_pkg::REG_ORIGIN_Y:   n_cfg.origin_y = signed'(i_data);
                vom_pkg::REG_ORIGIN_Z:   n_cfg.origin_z = signed'(i_data);
                vom_pkg::REG_INV_WIDTH:  n_cfg.inverse_voxel_width = i_data[vom_pkg::INV_W-1:0];
                vom_pkg::REG_GRID_X:     n_cfg.grid_size_x = i_data[6:0];
                vom_pkg::REG_GRID_Y:     n_cfg.grid_size_y = i_data[6:0];
                vom_pkg::REG_GRID_Z:     n_cfg.grid_size_z = i_data[5:0];
                vom_pkg::REG_ACCUMULATE: n_cfg.accumulate = i_data[0];
                default:                 n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.origin_x            <= '0;
            r_cfg.origin_y            <= '0;
            r_cfg.origin_z            <= '0;
            r_cfg.inverse_voxel_width <= vom_pkg::INV_W'(65536);
            r_cfg.grid_size_x         <= 7'd64;
            r_cfg.grid_size_y         <= 7'd64;
            r_cfg.grid_size_z         <= 6'd32;
            r_cfg.accumulate          <= 1'b0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

[hw/rtl/voxel_occupancy_marker.sv]
// ----------------------------------------------------------------------------
// voxel_occupancy_marker: 3-D point to occupancy bitmap marker
// Scales each point into a voxel index with one shared multiplier, builds the
// linear voxel key and sets the voxel's bit in a RAM bitmap while keeping a
// running count of occupied voxels.
// ----------------------------------------------------------------------------
//
//  Channel   Dir   Handshake          Word
//  i_pt      in    valid / ready      point_x/y/z (Q16.16), point_valid, scan_start
//  o_res     out   valid / ready      in_map, voxel_key, newly_marked, occupied_count
//  i_cfg_*   in    write enable only  register index, 32-bit data
//
// A word is accepted in the idle state; its result reaches the output register
// after three multiplier passes for the axis scalings, two for the key, a bitmap
// row read and a read-modify-write; the next word is taken only back in idle.
// A scan start without accumulate first clears the bitmap one 64-bit row per cycle
// through all ROW_COUNT (2048) rows; the same sweep runs after reset before any word.
// A result waiting in the output register stalls only the final update.
// ----------------------------------------------------------------------------
`default_nettype none

module voxel_occupancy_marker (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic [vom_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire logic [vom_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    vom_pt_if.sink                               i_pt,
    vom_res_if.source                            o_res
);

    vom_pkg::t_cfg  cfg;
    vom_pkg::t_state r_state;
    vom_pkg::t_state n_state;

    // Clamped grid sizes.
    logic [vom_pkg::SX_W-1:0] sx;
    logic [vom_pkg::SY_W-1:0] sy;
    logic [vom_pkg::SZ_W-1:0] sz;

    // Working registers of the current word.
    logic signed [vom_pkg::DIFF_W-1:0] r_diff_x, r_diff_y, r_diff_z;
    logic                              r_hit;
    logic                              r_run_after;
    logic [vom_pkg::IX_W-1:0]          r_ix;
    logic [vom_pkg::IY_W-1:0]          r_iy;
    logic [vom_pkg::KEY_W-1:0]         r_key;
    logic [vom_pkg::ROW_AW-1:0]        r_clr_row;
    logic [vom_pkg::COUNT_W-1:0]       r_count;

    // Output register.
    logic                              r_out_valid;
    logic                              r_out_in_map;
    logic [vom_pkg::KEY_OUT_W-1:0]     r_out_key;
    logic                              r_out_new;
    logic [vom_pkg::COUNT_W-1:0]       r_out_count;

    // Shared multiplier.
    logic signed [vom_pkg::DIFF_W-1:0]  mul_a;
    logic signed [vom_pkg::MUL_B_W-1:0] mul_b;
    logic signed [vom_pkg::PROD_W-1:0]  prod;

    // Bitmap RAM.
    logic                           ram_we;
    logic [vom_pkg::ROW_AW-1:0]     ram_waddr;
    logic [vom_pkg::ROW_W-1:0]      ram_wdata;
    logic                           ram_re;
    logic [vom_pkg::ROW_W-1:0]      ram_rdata;

    // Sequencer controls.
    logic accept;
    logic clr_go;
    logic out_free;
    logic clr_last;
    logic do_update;

    // Derived values.
    logic [vom_pkg::IDXF_W-1:0]     idx_full;
    logic                           prod_neg;
    logic                           ok_x, ok_y, ok_z;
    logic [vom_pkg::IZ_W-1:0]       iz_now;
    logic [vom_pkg::KEY_W-1:0]      key_now;
    logic [vom_pkg::BIT_W-1:0]      bit_sel;
    logic [vom_pkg::ROW_W-1:0]      bit_mask;
    logic                           bit_was_set;
    logic                           fresh;
    logic [vom_pkg::KEY_W+vom_pkg::KEY_OUT_W-1:0] key_wide;

    vom_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (i_cfg_we),
        .i_idx   (i_cfg_idx),
        .i_data  (i_cfg_data),
        .o_cfg   (cfg)
    );

    vom_mul u_mul (
        .i_clk (i_clk),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (prod)
    );

    vom_ram #(
        .WIDTH (vom_pkg::ROW_W),
        .DEPTH (vom_pkg::ROW_COUNT)
    ) u_bitmap (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (vom_pkg::ROW_AW'(key_now >> vom_pkg::BIT_W)),
        .o_rdata (ram_rdata)
    );

    // Grid sizes saturate at the bitmap limits.
    assign sx = (32'(cfg.grid_size_x) > vom_pkg::MAX_GRID_X) ?
                vom_pkg::SX_W'(vom_pkg::MAX_GRID_X) : vom_pkg::SX_W'(cfg.grid_size_x);
    assign sy = (32'(cfg.grid_size_y) > vom_pkg::MAX_GRID_Y) ?
                vom_pkg::SY_W'(vom_pkg::MAX_GRID_Y) : vom_pkg::SY_W'(cfg.grid_size_y);
    assign sz = (32'(cfg.grid_size_z) > vom_pkg::MAX_GRID_Z) ?
                vom_pkg::SZ_W'(vom_pkg::MAX_GRID_Z) : vom_pkg::SZ_W'(cfg.grid_size_z);

    // Handshake and sequencer conditions.
    assign i_pt.ready = (r_state == vom_pkg::S_IDLE);
    assign accept     = i_pt.valid && i_pt.ready;
    assign clr_go     = accept && i_pt.scan_start && !cfg.accumulate;
    assign out_free   = !r_out_valid || o_res.ready;
    assign clr_last   = (r_clr_row == vom_pkg::ROW_AW'(vom_pkg::ROW_COUNT - 1));
    assign do_update  = (r_state == vom_pkg::S_UPDATE) && out_free;

    // Floor of the scaled coordinate and its range check on each axis.
    assign prod_neg = prod[vom_pkg::PROD_W-1];
    assign idx_full = prod[vom_pkg::PROD_W-2:vom_pkg::FRAC_W];
    assign ok_x     = !prod_neg && (idx_full < vom_pkg::IDXF_W'(sx));
    assign ok_y     = !prod_neg && (idx_full < vom_pkg::IDXF_W'(sy));
    assign ok_z     = !prod_neg && (idx_full < vom_pkg::IDXF_W'(sz));
    assign iz_now   = prod[vom_pkg::FRAC_W +: vom_pkg::IZ_W];

    // Last key step: add the x index to sx * (y + sy * z).
    assign key_now  = vom_pkg::KEY_W'(prod[vom_pkg::KEY_W-1:0] + vom_pkg::KEY_W'(r_ix));

    // Bit within the bitmap row.
    assign bit_sel     = r_key[vom_pkg::BIT_W-1:0];
    assign bit_mask    = vom_pkg::ROW_W'(1) << bit_sel;
    assign bit_was_set = |(ram_rdata & bit_mask);
    assign fresh       = r_hit && !bit_was_set;
    assign key_wide    = (vom_pkg::KEY_W + vom_pkg::KEY_OUT_W)'(r_key);

    // Multiplier operand selection.
    always_comb begin
        case (r_state)
            vom_pkg::S_MUL_Y: begin
                mul_a = r_diff_y;
                mul_b = signed'({1'b0, cfg.inverse_voxel_width});
            end
            vom_pkg::S_MUL_Z: begin
                mul_a = r_diff_z;
                mul_b = signed'({1'b0, cfg.inverse_voxel_width});
            end
            vom_pkg::S_KEY_Z: begin
                mul_a = signed'(vom_pkg::DIFF_W'(sy));
                mul_b = signed'(vom_pkg::MUL_B_W'(iz_now));
            end
            vom_pkg::S_KEY_Y: begin
                mul_a = signed'(vom_pkg::DIFF_W'(sx));
                mul_b = signed'(vom_pkg::MUL_B_W'(prod[vom_pkg::MUL_B_W-1:0]
                                                  + vom_pkg::MUL_B_W'(r_iy)));
            end
            default: begin
                mul_a = r_diff_x;
                mul_b = signed'({1'b0, cfg.inverse_voxel_width});
            end
        endcase
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            vom_pkg::S_CLEAR: begin
                if (clr_last) begin
                    n_state = r_run_after ? vom_pkg::S_MUL_X : vom_pkg::S_IDLE;
                end
            end
            vom_pkg::S_IDLE: begin
                if (clr_go) begin
                    n_state = vom_pkg::S_CLEAR;
                end else if (accept) begin
                    n_state = vom_pkg::S_MUL_X;
                end
            end
            vom_pkg::S_MUL_X:  n_state = vom_pkg::S_MUL_Y;
            vom_pkg::S_MUL_Y:  n_state = vom_pkg::S_MUL_Z;
            vom_pkg::S_MUL_Z:  n_state = vom_pkg::S_KEY_Z;
            vom_pkg::S_KEY_Z:  n_state = vom_pkg::S_KEY_Y;
            vom_pkg::S_KEY_Y:  n_state = vom_pkg::S_READ;
            vom_pkg::S_READ:   n_state = vom_pkg::S_UPDATE;
            vom_pkg::S_UPDATE: begin
                if (out_free) begin
                    n_state = vom_pkg::S_IDLE;
                end
            end
            default: n_state = vom_pkg::S_CLEAR;
        endcase
    end

    // Bitmap port controls: the clearing sweep or the read-modify-write.
    always_comb begin
        ram_re    = 1'b0;
        ram_we    = 1'b0;
        ram_waddr = vom_pkg::ROW_AW'(r_key >> vom_pkg::BIT_W);
        ram_wdata = ram_rdata | bit_mask;
        case (r_state)
            vom_pkg::S_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = r_clr_row;
                ram_wdata = '0;
            end
            vom_pkg::S_READ: begin
                ram_re = 1'b1;
            end
            vom_pkg::S_UPDATE: begin
                ram_we = out_free && fresh;
            end
            default: begin
                ram_re = 1'b0;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= vom_pkg::S_CLEAR;
            r_clr_row   <= '0;
            r_run_after <= 1'b0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == vom_pkg::S_CLEAR) begin
                r_clr_row <= clr_last ? '0 : r_clr_row + 1'b1;
            end
            if (accept) begin
                r_run_after <= 1'b1;
            end
            if (clr_go) begin
                r_count <= '0;
            end else if (do_update && fresh && (r_count != vom_pkg::COUNT_MAX)) begin
                r_count <= r_count + 1'b1;
            end
            if (do_update) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Datapath registers of the current word.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_diff_x <= vom_pkg::DIFF_W'(i_pt.point_x) - vom_pkg::DIFF_W'(cfg.origin_x);
            r_diff_y <= vom_pkg::DIFF_W'(i_pt.point_y) - vom_pkg::DIFF_W'(cfg.origin_y);
            r_diff_z <= vom_pkg::DIFF_W'(i_pt.point_z) - vom_pkg::DIFF_W'(cfg.origin_z);
            r_hit    <= i_pt.point_valid;
        end
        case (r_state)
            vom_pkg::S_MUL_Y: begin
                r_hit <= r_hit && ok_x;
                r_ix  <= prod[vom_pkg::FRAC_W +: vom_pkg::IX_W];
            end
            vom_pkg::S_MUL_Z: begin
                r_hit <= r_hit && ok_y;
                r_iy  <= prod[vom_pkg::FRAC_W +: vom_pkg::IY_W];
            end
            vom_pkg::S_KEY_Z: begin
                r_hit <= r_hit && ok_z;
            end
            vom_pkg::S_READ: begin
                r_key <= key_now;
            end
            default: begin
                r_key <= r_key;
            end
        endcase
    end

    // Result word.
    always_ff @(posedge i_clk) begin
        if (do_update) begin
            r_out_in_map <= r_hit;
            r_out_key    <= r_hit ? key_wide[vom_pkg::KEY_OUT_W-1:0] : '0;
            r_out_new    <= fresh;
            r_out_count  <= (fresh && (r_count != vom_pkg::COUNT_MAX)) ?
                            r_count + 1'b1 : r_count;
        end
    end

    assign o_res.valid          = r_out_valid;
    assign o_res.in_map         = r_out_in_map;
    assign o_res.voxel_key      = r_out_key;
    assign o_res.newly_marked   = r_out_new;
    assign o_res.occupied_count = r_out_count;

    // An accepted word starts either the scaling passes or a clearing sweep.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state == vom_pkg::S_MUL_X || r_state == vom_pkg::S_CLEAR))
        else $error("accepted word did not start the sequencer");

    // A voxel can only be newly marked by a point inside the map.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid |-> (!o_res.newly_marked || o_res.in_map))
        else $error("newly marked voxel outside the map");

    // The occupied count only falls through a scan-start clear.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$past(clr_go) |-> (r_count >= $past(r_count)))
        else $error("occupied count fell without a clear");

    // The bitmap is written only during clearing or the final update.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> (r_state == vom_pkg::S_CLEAR || (do_update && r_hit)))
        else $error("unexpected bitmap write");

endmodule

`default_nettype wire

[tb/voxel_occupancy_marker_tb.sv]
// ----------------------------------------------------------------------------
// voxel_occupancy_marker_tb: self-checking bench for the voxel occupancy marker
// A driver feeds point words from a queue and a monitor checks every result
// word against a bit-exact software copy of the marker: fixed-point scaling,
// grid bounds, key build, occupancy bitmap and count. Directed points cover
// the grid edges, origin and width extremes and scan-start clearing. Random
// phases then rewrite all registers and stream mostly in-grid points.
// ----------------------------------------------------------------------------
module voxel_occupancy_marker_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import vom_pkg::*;

    localparam int STUCK_LIMIT   = 20000;
    localparam int HOLD_AT       = 100;
    localparam int HOLD_CYCLES   = 400;
    localparam int PHASE_COUNT   = 12;
    localparam int PHASE_WORDS   = 158;

    typedef struct {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] z;
        logic                      point_valid;
        logic                      scan_start;
    } t_point_word;

    typedef struct {
        logic                 in_map;
        logic [KEY_OUT_W-1:0] voxel_key;
        logic                 newly_marked;
        logic [COUNT_W-1:0]   occupied_count;
    } t_mark_result;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    vom_pt_if  pt_bus();
    vom_res_if res_bus();

    voxel_occupancy_marker DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_pt       (pt_bus),
        .o_res      (res_bus)
    );

    // Software copy of the registers and of the occupancy store.
    t_cfg         cfg_mirror;
    bit           occ_map [CELL_TOTAL];
    int unsigned  occ_total;

    t_point_word  point_queue [$];
    t_point_word  recent_pts [$];
    t_mark_result expected_marks [$];
    t_point_word  cur_word;

    int words_sent;
    int words_accepted;
    int results_seen;
    int mismatches;
    int hold_left;
    bit hold_done;
    int stuck_cycles;
    int send_gap = 0;
    bit idle_on = 1'b1;

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    function automatic int unsigned clamp_size(input int unsigned v, input int unsigned lim);
        return (v > lim) ? lim : v;
    endfunction

    // Scale one coordinate into a voxel index; false when it falls off the grid.
    function automatic bit axis_bin(input logic signed [COORD_W-1:0] coord,
                                    input logic signed [COORD_W-1:0] org,
                                    input int unsigned size, output int unsigned idx);
        longint diff;
        longint prod;
        diff = longint'(coord) - longint'(org);
        prod = diff * longint'(cfg_mirror.inverse_voxel_width);
        idx  = 0;
        if (prod < 0)
            return 1'b0;
        if ((prod >>> 32) >= longint'(size))
            return 1'b0;
        idx = 32'(prod >>> 32);
        return 1'b1;
    endfunction

    // Work out the result word of one accepted point and update the bitmap.
    function automatic void mark_point(input t_point_word w);
        t_mark_result r;
        int unsigned  sx, sy, sz, ix, iy, iz, key;
        bit           hit;
        bit           fresh;
        sx    = clamp_size(cfg_mirror.grid_size_x, MAX_GRID_X);
        sy    = clamp_size(cfg_mirror.grid_size_y, MAX_GRID_Y);
        sz    = clamp_size(cfg_mirror.grid_size_z, MAX_GRID_Z);
        hit   = 1'b0;
        fresh = 1'b0;
        key   = 0;
        if (w.scan_start && !cfg_mirror.accumulate) begin
            occ_map   = '{default: 1'b0};
            occ_total = 0;
        end
        if (w.point_valid) begin
            hit = axis_bin(w.x, cfg_mirror.origin_x, sx, ix) &&
                  axis_bin(w.y, cfg_mirror.origin_y, sy, iy) &&
                  axis_bin(w.z, cfg_mirror.origin_z, sz, iz);
        end
        if (hit) begin
            key = ix + sx * (iy + sy * iz);
            if (!occ_map[key]) begin
                occ_map[key] = 1'b1;
                fresh        = 1'b1;
                occ_total++;
            end
        end
        r.in_map         = hit;
        r.voxel_key      = hit ? key[KEY_OUT_W-1:0] : '0;
        r.newly_marked   = fresh;
        r.occupied_count = occ_total[COUNT_W-1:0];
        expected_marks.insert(expected_marks.size(), r);
    endfunction

    function automatic void flag_mismatch(input string msg);
        mismatches++;
        if (mismatches <= 10)
            $display("mismatch %0d: %s", mismatches, msg);
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got, input int n);
        if (want !== got)
            flag_mismatch($sformatf("result %0d %s: expected %0d, got %0d", n, name, want, got));
    endfunction

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 70);
    endfunction

    function automatic longint unsigned rand64();
        return {$urandom, $urandom};
    endfunction

    // Coordinate whose offset from the origin mostly lands inside the grid.
    function automatic logic [COORD_W-1:0] axis_coord(input logic signed [COORD_W-1:0] org,
                                                      input int unsigned size);
        longint span;
        longint d;
        if (size == 0)
            size = 1;
        if (cfg_mirror.inverse_voxel_width == 0)
            span = 64'sh1_0000_0000;
        else
            span = (longint'(size) <<< 32) / longint'(cfg_mirror.inverse_voxel_width);
        if (span < 2)
            span = 2;
        d = longint'(rand64() % longint'(span + span / 8)) - span / 16;
        return 32'(longint'(org) + d);
    endfunction

    function automatic t_point_word random_point();
        t_point_word w;
        int          r;
        r = $urandom_range(0, 99);
        if (r < 12 && recent_pts.size() != 0) begin
            // Revisit a recent point so that occupied voxels are hit again.
            w = recent_pts[$urandom_range(0, recent_pts.size() - 1)];
        end else if (r < 22) begin
            w.x           = $urandom;
            w.y           = $urandom;
            w.z           = $urandom;
            w.point_valid = $urandom_range(0, 1);
        end else begin
            w.x = axis_coord(cfg_mirror.origin_x, clamp_size(cfg_mirror.grid_size_x, MAX_GRID_X));
            w.y = axis_coord(cfg_mirror.origin_y, clamp_size(cfg_mirror.grid_size_y, MAX_GRID_Y));
            w.z = axis_coord(cfg_mirror.origin_z, clamp_size(cfg_mirror.grid_size_z, MAX_GRID_Z));
            w.point_valid = ($urandom_range(0, 19) != 0);
            recent_pts.insert(recent_pts.size(), w);
            if (recent_pts.size() > 16)
                void'(recent_pts.pop_front());
        end
        w.scan_start = ($urandom_range(0, 69) == 0);
        return w;
    endfunction

    function automatic logic [COORD_W-1:0] random_origin();
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: return '0;
            default: return $urandom_range(0, 32'h01FF_FFFF) - 32'h0100_0000;
        endcase
    endfunction

    function automatic logic [INV_W-1:0] random_inv_width();
        case ($urandom_range(0, 4))
            0: return 24'd65536;
            1: return $urandom_range(1, 24'hFF_FFFF);
            2: return 24'd1 << $urandom_range(12, 20);
            3: return $urandom_range(0, 255);
            default: return $urandom_range(32768, 262144);
        endcase
    endfunction

    // Small grids most of the time, the whole field now and then.
    function automatic int unsigned random_grid(input int unsigned max_size);
        int r;
        r = $urandom_range(0, 9);
        if (r < 5)
            return $urandom_range(1, 6);
        if (r < 9)
            return $urandom_range(1, max_size);
        return $urandom_range(0, 2 * max_size - 1);
    endfunction

    function automatic t_cfg random_setting(input int phase);
        t_cfg s;
        s.origin_x            = random_origin();
        s.origin_y            = random_origin();
        s.origin_z            = random_origin();
        s.inverse_voxel_width = random_inv_width();
        s.grid_size_x         = 7'(random_grid(MAX_GRID_X));
        s.grid_size_y         = 7'(random_grid(MAX_GRID_Y));
        s.grid_size_z         = 6'(random_grid(MAX_GRID_Z));
        s.accumulate          = $urandom_range(0, 1);
        if (phase == 1) begin
            // Full-size grid at unit voxel width.
            s.origin_x            = '0;
            s.origin_y            = '0;
            s.origin_z            = '0;
            s.inverse_voxel_width = 24'd65536;
            s.grid_size_x         = 7'(MAX_GRID_X);
            s.grid_size_y         = 7'(MAX_GRID_Y);
            s.grid_size_z         = 6'(MAX_GRID_Z);
        end else if (phase == 2) begin
            // Single-voxel grid at the smallest nonzero width.
            s.inverse_voxel_width = 24'd1;
            s.grid_size_x         = 7'd1;
            s.grid_size_y         = 7'd1;
            s.grid_size_z         = 6'd1;
        end
        return s;
    endfunction

    task automatic write_reg(input t_cfg_reg idx, input logic [CFG_DATA_W-1:0] data);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            REG_ORIGIN_X:   cfg_mirror.origin_x = data;
            REG_ORIGIN_Y:   cfg_mirror.origin_y = data;
            REG_ORIGIN_Z:   cfg_mirror.origin_z = data;
            REG_INV_WIDTH:  cfg_mirror.inverse_voxel_width = data[INV_W-1:0];
            REG_GRID_X:     cfg_mirror.grid_size_x = data[6:0];
            REG_GRID_Y:     cfg_mirror.grid_size_y = data[6:0];
            REG_GRID_Z:     cfg_mirror.grid_size_z = data[5:0];
            REG_ACCUMULATE: cfg_mirror.accumulate = data[0];
            default:        ;
        endcase
    endtask

    task automatic apply_setting(input t_cfg s);
        write_reg(REG_ORIGIN_X, s.origin_x);
        write_reg(REG_ORIGIN_Y, s.origin_y);
        write_reg(REG_ORIGIN_Z, s.origin_z);
        write_reg(REG_INV_WIDTH, 32'(s.inverse_voxel_width));
        write_reg(REG_GRID_X, 32'(s.grid_size_x));
        write_reg(REG_GRID_Y, 32'(s.grid_size_y));
        write_reg(REG_GRID_Z, 32'(s.grid_size_z));
        write_reg(REG_ACCUMULATE, 32'(s.accumulate));
        @(negedge i_clk);
    endtask

    task automatic queue_word(input t_point_word w);
        point_queue.insert(point_queue.size(), w);
        words_sent++;
    endtask

    task automatic add_point(input logic [31:0] x, input logic [31:0] y, input logic [31:0] z,
                             input logic pv, input logic ss);
        t_point_word w;
        w.x           = x;
        w.y           = y;
        w.z           = z;
        w.point_valid = pv;
        w.scan_start  = ss;
        queue_word(w);
    endtask

    // The sender stops here until every queued word has its result back.
    task automatic settle();
        while (results_seen < words_sent)
            @(posedge i_clk);
        repeat (2) @(posedge i_clk);
    endtask

    // Point driver: offers queued words, with random gaps between them while idle_on is set.
    always @(posedge i_clk) begin : drive_words
        if (!i_rst_n) begin
            pt_bus.valid <= 1'b0;
        end else begin
            if (pt_bus.valid && pt_bus.ready) begin
                mark_point(cur_word);
                words_accepted <= words_accepted + 1;
            end
            if (!pt_bus.valid || pt_bus.ready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    pt_bus.valid <= 1'b0;
                end else if (point_queue.size() != 0) begin
                    cur_word = point_queue.pop_front();
                    pt_bus.point_x     <= cur_word.x;
                    pt_bus.point_y     <= cur_word.y;
                    pt_bus.point_z     <= cur_word.z;
                    pt_bus.point_valid <= cur_word.point_valid;
                    pt_bus.scan_start  <= cur_word.scan_start;
                    pt_bus.valid       <= 1'b1;
                    send_gap = idle_on ? pick_gap() : 0;
                end else begin
                    pt_bus.valid <= 1'b0;
                end
            end
        end
    end : drive_words

    // Result monitor: random back-pressure and field-by-field checking.
    always @(posedge i_clk) begin : check_results
        t_mark_result want_r;
        int           stall_left;
        if (!i_rst_n) begin
            res_bus.ready <= 1'b0;
            stall_left = 0;
        end else begin
            if (res_bus.valid && res_bus.ready) begin
                results_seen <= results_seen + 1;
                if (expected_marks.size() == 0) begin
                    flag_mismatch($sformatf("result %0d arrived with no point waiting",
                                            results_seen));
                end else begin
                    want_r = expected_marks.pop_front();
                    check_field("in_map", 32'(want_r.in_map), 32'(res_bus.in_map), results_seen);
                    check_field("voxel_key", 32'(want_r.voxel_key), 32'(res_bus.voxel_key),
                                results_seen);
                    check_field("newly_marked", 32'(want_r.newly_marked),
                                32'(res_bus.newly_marked), results_seen);
                    check_field("occupied_count", 32'(want_r.occupied_count),
                                32'(res_bus.occupied_count), results_seen);
                end
            end
            if (hold_left != 0) begin
                res_bus.ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                res_bus.ready <= 1'b0;
            end else begin
                res_bus.ready <= 1'b1;
                if (idle_on && $urandom_range(0, 3) == 0)
                    stall_left = pick_gap();
            end
        end
    end : check_results

    // One long receiver hold-off while the sender keeps offering words.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_left <= 0;
            hold_done <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end else if (!hold_done && words_accepted >= HOLD_AT) begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
    end

    // Watchdog on cycles where neither channel moves a word.
    always @(posedge i_clk) begin
        if (!i_rst_n || (pt_bus.valid && pt_bus.ready) || (res_bus.valid && res_bus.ready)) begin
            stuck_cycles <= 0;
        end else if (stuck_cycles >= STUCK_LIMIT) begin
            $display("voxel_occupancy_marker_tb failed");
            $finish;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
        end
    end

    initial begin : stimulus
        t_cfg s;
        int   p;
        int   k;
        pt_bus.valid       = 1'b0;
        pt_bus.point_x     = '0;
        pt_bus.point_y     = '0;
        pt_bus.point_z     = '0;
        pt_bus.point_valid = 1'b0;
        pt_bus.scan_start  = 1'b0;
        res_bus.ready      = 1'b0;

        // Reset values of the registers.
        cfg_mirror.origin_x            = '0;
        cfg_mirror.origin_y            = '0;
        cfg_mirror.origin_z            = '0;
        cfg_mirror.inverse_voxel_width = 24'd65536;
        cfg_mirror.grid_size_x         = 7'd64;
        cfg_mirror.grid_size_y         = 7'd64;
        cfg_mirror.grid_size_z         = 6'd32;
        cfg_mirror.accumulate          = 1'b0;
        occ_map   = '{default: 1'b0};
        occ_total = 0;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Reset settings: grid corners, bounds, repeat hit, invalid scan start.
        add_point(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b1, 1'b1);
        add_point(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b1, 1'b0);
        add_point(32'h003F_FFFF, 32'h003F_FFFF, 32'h001F_FFFF, 1'b1, 1'b0);
        add_point(32'h0040_0000, 32'h0000_0000, 32'h0000_0000, 1'b1, 1'b0);
        add_point(32'h0000_0000, 32'h0000_0000, 32'h0020_0000, 1'b1, 1'b0);
        add_point(32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0000, 1'b1, 1'b0);
        add_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, 1'b1, 1'b0);
        add_point(32'h0001_8000, 32'h0002_4000, 32'h0003_0000, 1'b0, 1'b0);
        add_point(32'h0001_8000, 32'h0002_4000, 32'h0003_0000, 1'b0, 1'b1);
        add_point(32'h0001_8000, 32'h0002_4000, 32'h0003_0000, 1'b1, 1'b0);

        // Extreme origins, widest reciprocal, oversized grid, accumulate on.
        settle();
        s.origin_x            = 32'h8000_0000;
        s.origin_y            = 32'h7FFF_FFFF;
        s.origin_z            = 32'hFFFF_0000;
        s.inverse_voxel_width = 24'hFF_FFFF;
        s.grid_size_x         = 7'd127;
        s.grid_size_y         = 7'd64;
        s.grid_size_z         = 6'd63;
        s.accumulate          = 1'b1;
        apply_setting(s);
        add_point(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_0000, 1'b1, 1'b1);
        add_point(32'h8000_0100, 32'h7FFF_FFFF, 32'hFFFF_0000, 1'b1, 1'b0);
        add_point(32'h8000_0101, 32'h7FFF_FFFF, 32'hFFFF_0000, 1'b1, 1'b0);
        add_point(32'h8000_3F00, 32'h7FFF_FFFF, 32'hFFFF_0000, 1'b1, 1'b0);
        add_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_0000, 1'b1, 1'b0);
        add_point(32'h8000_0000, 32'h8000_0000, 32'hFFFF_0000, 1'b1, 1'b0);

        // Zero reciprocal width: every valid point maps to voxel zero.
        settle();
        s.inverse_voxel_width = '0;
        s.grid_size_x         = 7'd1;
        s.grid_size_y         = 7'd5;
        s.grid_size_z         = 6'd1;
        s.accumulate          = 1'b0;
        apply_setting(s);
        add_point(32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000, 1'b1, 1'b0);
        add_point(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 1'b1, 1'b0);
        add_point(32'h1234_5678, 32'hEDCB_A987, 32'h5555_AAAA, 1'b1, 1'b1);

        // Zero grid size on x rejects everything.
        settle();
        s.grid_size_x = 7'd0;
        apply_setting(s);
        add_point(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b1, 1'b0);
        add_point(32'hAAAA_5555, 32'h0F0F_F0F0, 32'h3333_CCCC, 1'b1, 1'b0);

        // Random phases, each under a fresh register setting.
        for (p = 0; p < PHASE_COUNT; p++) begin
            settle();
            apply_setting(random_setting(p));
            idle_on = (p % 4 != 3);
            for (k = 0; k < PHASE_WORDS; k++)
                queue_word(random_point());
        end

        settle();
        repeat (20) @(posedge i_clk);
        if (mismatches == 0 && expected_marks.size() == 0)
            $display("voxel_occupancy_marker_tb passed");
        else
            $display("voxel_occupancy_marker_tb failed");
        $finish;
    end : stimulus

endmodule
